/* hw/rtl/bvm_pkg.sv */
// ----------------------------------------------------------------------------
// bvm_pkg
// Types and constants shared by the battery voltage monitor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bvm_pkg;

  // widths of the item fields
  localparam int READING_W = 16;
  localparam int INTEG_W   = 8;
  localparam int LEVEL_W   = 3;
  localparam int HOLD_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // number of entries in the threshold table
  localparam int LIMIT_N = 16;

  // reset value of the level hold counter
  localparam logic [HOLD_W-1:0] LEVEL_HOLD_RESET = 8'd8;

  // level thresholds, unused entries never exceeded
  localparam logic [READING_W-1:0] LEVEL_LIMITS [LIMIT_N] = '{
    16'h1088, 16'h1222, 16'h13BB, 16'h1444, 16'h14A3, 16'h1570, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
  };

  // configuration register reset values
  localparam logic [READING_W-1:0] STATE_HIGH_RESET  = 16'd2949;
  localparam logic [READING_W-1:0] STATE_LOW_RESET   = 16'd2785;
  localparam logic [READING_W-1:0] DISCHARGE_RESET   = 16'd2457;
  localparam logic [READING_W-1:0] RECHARGE_RESET    = 16'd2621;
  localparam logic [INTEG_W-1:0]   INTEG_MAX_RESET   = 8'd100;
  localparam logic [INTEG_W-1:0]   INTEG_MIN_RESET   = 8'd10;
  localparam logic [HOLD_W-1:0]    LEVEL_HOLD_CFG_RESET = 8'd8;
  localparam logic [HOLD_W-1:0]    FULL_HOLD_CFG_RESET  = 8'd8;

  // item kinds
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATE_HIGH  = 3'd0,
    REG_STATE_LOW   = 3'd1,
    REG_DISCHARGE   = 3'd2,
    REG_RECHARGE    = 3'd3,
    REG_INTEG_MAX   = 3'd4,
    REG_INTEG_MIN   = 3'd5,
    REG_LEVEL_HOLD  = 3'd6,
    REG_FULL_HOLD   = 3'd7
  } cfg_reg_t;

  // configuration set seen by the update logic
  typedef struct packed {
    logic [READING_W-1:0] state_high_level;
    logic [READING_W-1:0] state_low_level;
    logic [READING_W-1:0] discharge_cutoff;
    logic [READING_W-1:0] recharge_release;
    logic [INTEG_W-1:0]   integrator_max;
    logic [INTEG_W-1:0]   integrator_min;
    logic [HOLD_W-1:0]    level_hold_ticks;
    logic [HOLD_W-1:0]    full_hold_ticks;
  } cfg_t;

  // one input word
  typedef struct packed {
    op_t                  op;
    logic [READING_W-1:0] battery_reading;
    logic                 charger_present;
    logic                 charge_ended;
  } item_t;

  // one result word
  typedef struct packed {
    logic               battery_full;
    logic               protected_res;
    logic               recharge_low;
    logic               discharge_low;
    logic               state_high;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bvm_integ.sv */
// ----------------------------------------------------------------------------
// bvm_integ
// One step of an integrating hysteresis counter with trip and midpoint reload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvm_integ (
  input  wire logic                       enable,
  input  wire logic                       rising,
  input  wire logic [bvm_pkg::INTEG_W-1:0] cnt,
  input  wire logic                       flag,
  input  wire logic [bvm_pkg::INTEG_W-1:0] max_val,
  input  wire logic [bvm_pkg::INTEG_W-1:0] min_val,
  output logic      [bvm_pkg::INTEG_W-1:0] cnt_next,
  output logic                            flag_next
);
  import bvm_pkg::*;

  logic [INTEG_W:0]   sum;
  logic [INTEG_W-1:0] mid;

  // midpoint of the trip points
  assign sum = {1'b0, max_val} + {1'b0, min_val};
  assign mid = sum[INTEG_W:1];

  // count towards a trip point, reload on trip
  always_comb begin
    cnt_next  = cnt;
    flag_next = flag;
    if (enable) begin
      if (rising) begin
        if (cnt >= max_val) begin
          cnt_next  = mid;
          flag_next = 1'b1;
        end else begin
          cnt_next = cnt + 8'd1;
        end
      end else begin
        if (cnt <= min_val) begin
          cnt_next  = mid;
          flag_next = 1'b0;
        end else begin
          cnt_next = cnt - 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bvm_state.sv */
// ----------------------------------------------------------------------------
// bvm_state
// Monitor state registers and their update for one sample or tick word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvm_state #(
  parameter int LEVEL_COUNT = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             update,
  input  wire bvm_pkg::item_t   item,
  input  wire bvm_pkg::cfg_t    cfg,
  output bvm_pkg::result_t      res_next
);
  import bvm_pkg::*;

  localparam int LVL_CNT_W = 4;

  logic [INTEG_W-1:0] state_integ, discharge_integ, recharge_integ;
  logic [INTEG_W-1:0] state_integ_next, discharge_integ_next, recharge_integ_next;
  logic               state_flag, discharge_flag, recharge_flag;
  logic               state_flag_next, discharge_flag_next, recharge_flag_next;
  logic               protect_latch, protect_latch_next;
  logic               full_flag, full_flag_next;
  logic [HOLD_W-1:0]  full_countdown, full_countdown_next;
  logic [LEVEL_W-1:0] current_level, current_level_next;
  logic [HOLD_W-1:0]  level_countdown, level_countdown_next;

  logic                 is_sample;
  logic [READING_W-1:0] rd;
  logic                 state_up, state_down;
  logic [LVL_CNT_W-1:0] lv_cnt;
  logic [LEVEL_W-1:0]   lv;

  assign is_sample  = (item.op == OP_SAMPLE);
  assign rd         = item.battery_reading;
  assign state_up   = (rd >= cfg.state_high_level);
  assign state_down = (rd <= cfg.state_low_level);

  // high/low state counter, holds between the two levels
  bvm_integ u_state_integ (
    .enable    (is_sample && (state_up || state_down)),
    .rising    (state_up),
    .cnt       (state_integ),
    .flag      (state_flag),
    .max_val   (cfg.integrator_max),
    .min_val   (cfg.integrator_min),
    .cnt_next  (state_integ_next),
    .flag_next (state_flag_next)
  );

  // discharge cutoff counter
  bvm_integ u_discharge_integ (
    .enable    (is_sample),
    .rising    (rd <= cfg.discharge_cutoff),
    .cnt       (discharge_integ),
    .flag      (discharge_flag),
    .max_val   (cfg.integrator_max),
    .min_val   (cfg.integrator_min),
    .cnt_next  (discharge_integ_next),
    .flag_next (discharge_flag_next)
  );

  // recharge block counter
  bvm_integ u_recharge_integ (
    .enable    (is_sample),
    .rising    (rd <= cfg.recharge_release),
    .cnt       (recharge_integ),
    .flag      (recharge_flag),
    .max_val   (cfg.integrator_max),
    .min_val   (cfg.integrator_min),
    .cnt_next  (recharge_integ_next),
    .flag_next (recharge_flag_next)
  );

  // raw level: leading thresholds exceeded
  always_comb begin
    logic run;
    run    = 1'b1;
    lv_cnt = '0;
    for (int i = 0; i < LIMIT_N - 1; i++) begin
      if (run && (i < LEVEL_COUNT) && (rd > LEVEL_LIMITS[i])) begin
        lv_cnt = lv_cnt + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  assign lv = lv_cnt[LEVEL_W-1:0];

  // level debounce, full flag and protect latch
  always_comb begin
    current_level_next   = current_level;
    level_countdown_next = level_countdown;
    full_flag_next       = full_flag;
    full_countdown_next  = full_countdown;
    protect_latch_next   = protect_latch;
    if (!is_sample) begin
      if (level_countdown != '0) level_countdown_next = level_countdown - 8'd1;
      if (full_countdown != '0) full_countdown_next = full_countdown - 8'd1;
    end else begin
      if (lv == current_level) begin
        level_countdown_next = cfg.level_hold_ticks;
      end else if (level_countdown == '0) begin
        level_countdown_next = cfg.level_hold_ticks;
        current_level_next   = lv;
      end

      if (item.charger_present) begin
        if (item.charge_ended) begin
          if (full_countdown == '0) full_flag_next = 1'b1;
        end else begin
          full_countdown_next = cfg.full_hold_ticks;
        end
      end else begin
        full_flag_next      = 1'b0;
        full_countdown_next = cfg.full_hold_ticks;
      end

      if (protect_latch) begin
        if (!recharge_flag_next && item.charger_present) protect_latch_next = 1'b0;
      end else if (discharge_flag_next) begin
        protect_latch_next = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_integ     <= '0;
      discharge_integ <= '0;
      recharge_integ  <= '0;
      state_flag      <= 1'b0;
      discharge_flag  <= 1'b0;
      recharge_flag   <= 1'b0;
      protect_latch   <= 1'b0;
      full_flag       <= 1'b0;
      full_countdown  <= '0;
      current_level   <= '0;
      level_countdown <= LEVEL_HOLD_RESET;
    end else if (update) begin
      state_integ     <= state_integ_next;
      discharge_integ <= discharge_integ_next;
      recharge_integ  <= recharge_integ_next;
      state_flag      <= state_flag_next;
      discharge_flag  <= discharge_flag_next;
      recharge_flag   <= recharge_flag_next;
      protect_latch   <= protect_latch_next;
      full_flag       <= full_flag_next;
      full_countdown  <= full_countdown_next;
      current_level   <= current_level_next;
      level_countdown <= level_countdown_next;
    end
  end

  // result reports the state after this word
  always_comb begin
    res_next.level         = current_level_next;
    res_next.state_high    = state_flag_next;
    res_next.discharge_low = discharge_flag_next;
    res_next.recharge_low  = recharge_flag_next;
    res_next.protected_res = protect_latch_next;
    res_next.battery_full  = full_flag_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/battery_voltage_monitor_core.sv */
// ----------------------------------------------------------------------------
// battery_voltage_monitor_core
// Battery monitor: hysteresis flags, debounced level, full and protect status.
// ----------------------------------------------------------------------------
// Takes one word per clock while the result stream is not stalled. A word is
// registered in the input register on acceptance; when the output side is
// free, the monitor state is updated from that register and the result lands
// in the output register at the same edge. Every word, sample or tick, gives
// exactly one result. The state update is combinational from the input
// register; the input register can take one new word while a result waits,
// and the input stalls while both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_monitor_core #(
  parameter int LEVEL_COUNT = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // battery_reading[15:0], charger_present[16], charge_ended[17], zero pad
  input  wire logic [bvm_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[0]: 0 sample, 1 tick
  input  wire logic                            s_tuser,
  // result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // level[2:0], state_high[3], discharge_low[4], recharge_low[5],
  // protected_res[6], battery_full[7]
  output logic      [bvm_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bvm_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import bvm_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    out_free;
  logic    advance;
  result_t res_next;
  result_t out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.state_high_level <= STATE_HIGH_RESET;
      cfg.state_low_level  <= STATE_LOW_RESET;
      cfg.discharge_cutoff <= DISCHARGE_RESET;
      cfg.recharge_release <= RECHARGE_RESET;
      cfg.integrator_max   <= INTEG_MAX_RESET;
      cfg.integrator_min   <= INTEG_MIN_RESET;
      cfg.level_hold_ticks <= LEVEL_HOLD_CFG_RESET;
      cfg.full_hold_ticks  <= FULL_HOLD_CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STATE_HIGH: cfg.state_high_level <= cfg_wdata;
        REG_STATE_LOW:  cfg.state_low_level  <= cfg_wdata;
        REG_DISCHARGE:  cfg.discharge_cutoff <= cfg_wdata;
        REG_RECHARGE:   cfg.recharge_release <= cfg_wdata;
        REG_INTEG_MAX:  cfg.integrator_max   <= cfg_wdata[INTEG_W-1:0];
        REG_INTEG_MIN:  cfg.integrator_min   <= cfg_wdata[INTEG_W-1:0];
        REG_LEVEL_HOLD: cfg.level_hold_ticks <= cfg_wdata[HOLD_W-1:0];
        REG_FULL_HOLD:  cfg.full_hold_ticks  <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: input stage moves on when the output stage is free
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op              <= op_t'(s_tuser);
      in_item.battery_reading <= s_tdata[READING_W-1:0];
      in_item.charger_present <= s_tdata[READING_W];
      in_item.charge_ended    <= s_tdata[READING_W+1];
    end
  end

  // monitor state and its update
  bvm_state #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .update   (advance),
    .item     (in_item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tdata = out_res;

endmodule

`default_nettype wire
